>>> rtl/assert_macros.svh
// Assertion helpers shared by the RTL files.
// Each macro checks on the rising edge of clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assert that prop holds at every clock edge.
`define WGEC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Assert that expr is never true.
`define WGEC_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

>>> rtl/wgec_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wgec_pkg
// Field widths, constants and shared types of the wire grid centroid.
// ----------------------------------------------------------------------------
package wgec_pkg;

    localparam int CH_W      = 5;   // hit_channel
    localparam int EN_W      = 16;  // hit_energy
    localparam int POS_W     = 13;  // position, signed
    localparam int S_TDATA_W = 24;  // channel + energy, padded to bytes
    localparam int M_TDATA_W = 16;  // position, padded to bytes

    // grid center times two (15.5 * 2)
    localparam int CENTER_X2 = 31;

    // event queue status seen by the front and back parts
    typedef struct packed {
        logic full;
        logic not_empty;
    } q_stat_t;

endpackage

>>> rtl/wgec_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wgec_front
// Hit accumulator: classify each hit, sum energy and energy times channel,
// push both sums to the event queue on the last hit.
// ----------------------------------------------------------------------------
module wgec_front #(
    parameter int MAX_HITS = 32,
    parameter int ES_W     = 22,
    parameter int WS_W     = 27
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  adjacent_mode,
    input  logic                  hit_valid,
    output logic                  hit_ready,
    input  logic [wgec_pkg::CH_W-1:0] hit_channel,
    input  logic [wgec_pkg::EN_W-1:0] hit_energy,
    input  logic                  last_hit,
    input  wgec_pkg::q_stat_t     q_stat,
    output logic                  q_push,
    output logic [WS_W+ES_W-1:0]  q_wdata
);
    import wgec_pkg::*;

    localparam int HC_W = $clog2(MAX_HITS + 1);

    logic [WS_W-1:0] ws_reg, ws_next;
    logic [ES_W-1:0] es_reg, es_next;
    logic [CH_W-1:0] fc_reg, fc_next;
    logic            first_reg, first_next;
    logic [HC_W-1:0] hc_reg, hc_next;

    logic                 accept;
    logic                 room;
    logic                 take;
    logic [CH_W:0]        fc_up;
    logic [CH_W-1:0]      fc_dn;
    logic [EN_W+CH_W-1:0] prod;

    assign hit_ready = !q_stat.full;
    assign accept    = hit_valid && hit_ready;
    assign room      = hc_reg < HC_W'(MAX_HITS);
    assign fc_up     = {1'b0, fc_reg} + (CH_W+1)'(1);
    assign fc_dn     = fc_reg - CH_W'(1);
    assign prod      = (EN_W+CH_W)'(hit_energy) * (EN_W+CH_W)'(hit_channel);

    always_comb begin
        take = 1'b1;
        if (!first_reg && adjacent_mode) begin
            take = ({1'b0, hit_channel} == fc_up) ||
                   (fc_reg != '0 && hit_channel == fc_dn);
        end
    end

    always_comb begin
        ws_next    = ws_reg;
        es_next    = es_reg;
        fc_next    = fc_reg;
        first_next = first_reg;
        hc_next    = hc_reg;
        if (accept && room) begin
            if (first_reg) begin
                fc_next    = hit_channel;
                first_next = 1'b0;
            end
            if (take) begin
                ws_next = ws_reg + WS_W'(prod);
                es_next = es_reg + ES_W'(hit_energy);
            end
            hc_next = hc_reg + HC_W'(1);
        end
    end

    // push the finished sums, then start a fresh event
    assign q_push  = accept && last_hit;
    assign q_wdata = {ws_next, es_next};

    always_ff @(posedge aclk) begin
        if (!aresetn || q_push) begin
            ws_reg    <= '0;
            es_reg    <= '0;
            fc_reg    <= '0;
            first_reg <= 1'b1;
            hc_reg    <= '0;
        end else begin
            ws_reg    <= ws_next;
            es_reg    <= es_next;
            fc_reg    <= fc_next;
            first_reg <= first_next;
            hc_reg    <= hc_next;
        end
    end

endmodule

>>> rtl/wgec_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wgec_queue
// Two-entry event queue between the hit accumulator and the divider.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module wgec_queue #(
    parameter int W = 49
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  logic [W-1:0]      wdata,
    input  logic              pop,
    output logic [W-1:0]      rdata,
    output wgec_pkg::q_stat_t stat
);
    import wgec_pkg::*;

    logic [W-1:0] mem_reg [2];
    logic         wr_ptr_reg;
    logic         rd_ptr_reg;
    logic [1:0]   cnt_reg;

    assign rdata          = mem_reg[rd_ptr_reg];
    assign stat.full      = cnt_reg == 2'd2;
    assign stat.not_empty = cnt_reg != 2'd0;

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            unique case ({push, pop})
                2'b10:   cnt_reg <= cnt_reg + 2'd1;
                2'b01:   cnt_reg <= cnt_reg - 2'd1;
                default: cnt_reg <= cnt_reg;
            endcase
        end
    end

    `WGEC_NEVER(a_no_overflow, aclk, aresetn, push && stat.full, "push into full queue")
    `WGEC_NEVER(a_no_underflow, aclk, aresetn, pop && !stat.not_empty, "pop from empty queue")
    `WGEC_NEVER(a_cnt_range, aclk, aresetn, cnt_reg == 2'd3, "queue count out of range")

endmodule

>>> rtl/wgec_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wgec_back
// Restoring divider, one quotient bit per cycle, plus centering and the
// result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module wgec_back #(
    parameter int FRAC_BITS = 8,
    parameter int ES_W      = 22,
    parameter int WS_W      = 27
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  wgec_pkg::q_stat_t        q_stat,
    input  logic [WS_W+ES_W-1:0]     q_rdata,
    output logic                     q_pop,
    output logic                     res_valid,
    input  logic                     res_ready,
    output logic [wgec_pkg::POS_W-1:0] res_position,
    output logic                     res_empty
);
    import wgec_pkg::*;

    // quotient is below 32 * 2^FRAC_BITS since the weighted mean channel is below 32
    localparam int Q_W   = CH_W + FRAC_BITS;
    localparam int CNT_W = $clog2(Q_W + 1);
    localparam int D_W   = (Q_W + 1 > POS_W) ? Q_W + 1 : POS_W;
    localparam logic [D_W-1:0]   CENTER     = D_W'((CENTER_X2 << FRAC_BITS) >> 1);
    localparam logic [D_W-1:0]   NEG_CENTER_D = D_W'(0) - CENTER;
    localparam logic [POS_W-1:0] NEG_CENTER = NEG_CENTER_D[POS_W-1:0];

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [ES_W:0]    rem_reg, rem_next;
    logic [Q_W-1:0]   num_reg, num_next;
    logic [ES_W-1:0]  div_reg, div_next;
    logic             empty_reg, empty_next;
    logic             vld_reg, vld_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic             eout_reg, eout_next;

    logic [WS_W-1:0] q_ws;
    logic [ES_W-1:0] q_es;
    logic [ES_W:0]   trial;
    logic            qbit;
    logic            slot_free;
    logic [D_W-1:0]  diff;

    assign q_ws      = q_rdata[WS_W+ES_W-1:ES_W];
    assign q_es      = q_rdata[ES_W-1:0];
    assign trial     = {rem_reg[ES_W-1:0], num_reg[Q_W-1]};
    assign qbit      = trial >= {1'b0, div_reg};
    assign slot_free = !vld_reg || res_ready;
    assign q_pop     = (state_reg == ST_IDLE) && q_stat.not_empty;
    assign diff      = (empty_reg ? D_W'(0) : D_W'(num_reg)) - CENTER;

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        rem_next   = rem_reg;
        num_next   = num_reg;
        div_next   = div_reg;
        empty_next = empty_reg;
        vld_next   = vld_reg && !res_ready;
        pos_next   = pos_reg;
        eout_next  = eout_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (q_pop) begin
                    // high part of (ws << FRAC_BITS) is already below the divisor
                    rem_next   = {1'b0, q_ws[WS_W-1:CH_W]};
                    num_next   = Q_W'(q_ws[CH_W-1:0]) << FRAC_BITS;
                    div_next   = q_es;
                    empty_next = q_es == '0;
                    cnt_next   = CNT_W'(Q_W);
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                rem_next = qbit ? trial - {1'b0, div_reg} : trial;
                num_next = {num_reg[Q_W-2:0], qbit};
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1)) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (slot_free) begin
                    vld_next   = 1'b1;
                    pos_next   = diff[POS_W-1:0];
                    eout_next  = empty_reg;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            vld_reg   <= 1'b0;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            vld_reg   <= vld_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg   <= rem_next;
        num_reg   <= num_next;
        div_reg   <= div_next;
        empty_reg <= empty_next;
        pos_reg   <= pos_next;
        eout_reg  <= eout_next;
    end

    assign res_valid    = vld_reg;
    assign res_position = pos_reg;
    assign res_empty    = eout_reg;

    `WGEC_ASSERT(a_pop_idle, aclk, aresetn, q_pop |-> state_reg == ST_IDLE, "pop while dividing")
    `WGEC_ASSERT(a_cnt_live, aclk, aresetn, state_reg == ST_DIV |-> cnt_reg != '0, "divider count ran out")
    `WGEC_ASSERT(a_empty_pos, aclk, aresetn, (vld_reg && eout_reg) |-> pos_reg == NEG_CENTER, "empty result not at -center")

endmodule

>>> rtl/wire_grid_energy_centroid.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wire_grid_energy_centroid
// Energy-weighted centroid of one wire grid event, relative to the grid center.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one hit per beat. s_tdata holds hit_channel and hit_energy,
//   s_tlast marks the last hit of the event. Hits are taken one per cycle
//   while the event queue has room (two finished events may wait in it).
//   m_ channel: one result beat per event, after its last hit. m_tdata holds
//   position (signed, FRAC_BITS fractional bits, centroid minus 15.5);
//   m_tuser flags an event whose energy sum is zero.
//   After the last hit an event passes the queue, the divider load,
//   FRAC_BITS + 5 quotient bits (one per cycle) and the result register.
//   The divider takes a new event only after its result has moved on to
//   the result register; this divider loop sets the event rate.
//   Hits beyond MAX_HITS in one event add nothing but still end it on tlast.
//   Stall: while m_tready is low the result holds, the divider holds its
//   quotient, the queue fills and s_tready drops once two events wait.
//   Synchronous reset (aresetn low) clears event, queue, result, adjacent_mode.
//   The user writes adjacent_mode (cfg_we) only while idle; nothing checks it.
// ----------------------------------------------------------------------------
module wire_grid_energy_centroid #(
    parameter int MAX_HITS  = 32,
    parameter int FRAC_BITS = 8
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic                            cfg_wdata,   // adjacent_mode
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [wgec_pkg::S_TDATA_W-1:0]  s_tdata,     // hit_channel[4:0], hit_energy[20:5]
    input  logic                            s_tlast,     // last_hit
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [wgec_pkg::M_TDATA_W-1:0]  m_tdata,     // position[12:0]
    output logic                            m_tuser      // empty_res
);
    import wgec_pkg::*;

    // energy sum grows by the hit count, weighted sum by the channel range
    localparam int ES_W = EN_W + $clog2(MAX_HITS + 1);
    localparam int WS_W = ES_W + CH_W;

    logic                 adj_reg;
    q_stat_t              q_stat;
    logic                 q_push;
    logic                 q_pop;
    logic [WS_W+ES_W-1:0] q_wdata;
    logic [WS_W+ES_W-1:0] q_rdata;
    logic [POS_W-1:0]     position;

    // hold the mode register; the user writes it only between events, unchecked here
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            adj_reg <= 1'b0;
        end else if (cfg_we) begin
            adj_reg <= cfg_wdata;
        end
    end

    // front: classify and accumulate hits
    wgec_front #(
        .MAX_HITS (MAX_HITS),
        .ES_W     (ES_W),
        .WS_W     (WS_W)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .adjacent_mode (adj_reg),
        .hit_valid     (s_tvalid),
        .hit_ready     (s_tready),
        .hit_channel   (s_tdata[CH_W-1:0]),
        .hit_energy    (s_tdata[CH_W+EN_W-1:CH_W]),
        .last_hit      (s_tlast),
        .q_stat        (q_stat),
        .q_push        (q_push),
        .q_wdata       (q_wdata)
    );

    // queue finished events so the front keeps taking hits during division
    wgec_queue #(
        .W (WS_W + ES_W)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .wdata   (q_wdata),
        .pop     (q_pop),
        .rdata   (q_rdata),
        .stat    (q_stat)
    );

    // back: divide, subtract the center, register the result beat
    wgec_back #(
        .FRAC_BITS (FRAC_BITS),
        .ES_W      (ES_W),
        .WS_W      (WS_W)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_stat       (q_stat),
        .q_rdata      (q_rdata),
        .q_pop        (q_pop),
        .res_valid    (m_tvalid),
        .res_ready    (m_tready),
        .res_position (position),
        .res_empty    (m_tuser)
    );

    // pad position with zeros up to the byte boundary
    assign m_tdata = M_TDATA_W'(position);

endmodule

>>> test/wire_grid_energy_centroid_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wire_grid_energy_centroid_tb
// Self-checking bench for the wire grid energy centroid. Hit beats are driven
// on the s_ stream and each result beat on the m_ stream is compared with a
// predicted centroid. The predicted centroid comes from an internal model of
// the event sums and adjacency rule. The bench covers both adjacency modes,
// empty events, hits past the per-event maximum, random idle cycles on both
// sides, and a long result stall that backs the block up.
// ----------------------------------------------------------------------------
module wire_grid_energy_centroid_tb;

    localparam int MAX_HITS    = 32;
    localparam int FRAC        = 8;
    localparam int CENTER      = (wgec_pkg::CENTER_X2 << FRAC) >> 1;
    localparam int DRAIN_WAIT  = 40;    // settle time after the last expected result
    localparam int STALL_LEN   = 300;   // long result-side hold-off, in cycles

    // Expected centroids, oldest first, plus the model of the event sums.
    class centroid_scoreboard;
        typedef struct {
            logic [wgec_pkg::POS_W-1:0] pos;
            bit                         empty;
        } centroid_t;

        bit          adjacent;
        logic [25:0] wsum;
        logic [20:0] esum;
        logic [4:0]  first_ch;
        bit          want_first;
        int          hit_count;
        centroid_t   pending_centroids[$];
        int          errors;
        int          n_hits;
        int          n_results;
        int          n_empty;
        int          n_dropped;

        function new();
            adjacent = 1'b0;
            errors = 0;
            n_hits = 0;
            n_results = 0;
            n_empty = 0;
            n_dropped = 0;
            clear_event();
        endfunction

        function void clear_event();
            wsum = '0;
            esum = '0;
            first_ch = '0;
            want_first = 1'b1;
            hit_count = 0;
        endfunction

        // Fold one accepted hit into the sums; on the last hit queue a centroid.
        function void accept_hit(logic [4:0] ch, logic [15:0] en, bit last);
            bit          take;
            logic [63:0] quot;
            centroid_t   c;
            take = 1'b1;
            n_hits++;
            if (hit_count < MAX_HITS) begin
                if (want_first) begin
                    first_ch = ch;
                    want_first = 1'b0;
                end else if (adjacent) begin
                    take = (int'(ch) == int'(first_ch) + 1) ||
                           (first_ch != 0 && int'(ch) == int'(first_ch) - 1);
                end
                if (take) begin
                    wsum = wsum + 26'(en) * 26'(ch);
                    esum = esum + 21'(en);
                end
                hit_count++;
            end else begin
                n_dropped++;
            end
            if (last) begin
                c.empty = (esum == 0);
                quot = c.empty ? 64'd0 : (64'(wsum) << FRAC) / 64'(esum);
                c.pos = wgec_pkg::POS_W'(quot - 64'(CENTER));
                pending_centroids.push_back(c);
                if (c.empty)
                    n_empty++;
                clear_event();
            end
        endfunction

        function void check_centroid(logic [wgec_pkg::M_TDATA_W-1:0] tdata, logic tuser);
            centroid_t c;
            n_results++;
            if (pending_centroids.size() == 0) begin
                $error("result beat with no event pending: position %0d empty %0d",
                       $signed(tdata[wgec_pkg::POS_W-1:0]), tuser);
                errors++;
                return;
            end
            c = pending_centroids.pop_front();
            if (tdata[wgec_pkg::POS_W-1:0] !== c.pos) begin
                $error("position: expected %0d, got %0d",
                       $signed(c.pos), $signed(tdata[wgec_pkg::POS_W-1:0]));
                errors++;
            end
            if (tuser !== c.empty) begin
                $error("empty_res: expected %0d, got %0d", c.empty, tuser);
                errors++;
            end
        endfunction
    endclass

    logic                            aclk = 1'b0;
    logic                            aresetn;
    logic                            cfg_we;
    logic                            cfg_wdata;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [wgec_pkg::S_TDATA_W-1:0]  s_tdata;     // hit_channel[4:0], hit_energy[20:5]
    logic                            s_tlast;     // last_hit
    logic                            m_tvalid;
    logic                            m_tready;
    logic [wgec_pkg::M_TDATA_W-1:0]  m_tdata;     // position[12:0]
    logic                            m_tuser;     // empty_res

    centroid_scoreboard sb = new();
    int  snd_calm = 0;
    int  rcv_calm = 0;
    bit  hold_burst = 1'b0;
    bit  burst_done = 1'b0;

    wire_grid_energy_centroid #(
        .MAX_HITS  (MAX_HITS),
        .FRAC_BITS (FRAC)
    ) uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Random idle cycles before a beat, with runs of back-to-back beats.
    function automatic int draw_gap(inout int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 7) == 0) begin
            calm = $urandom_range(5, 30);
            return 0;
        end
        return $urandom_range(0, 10);
    endfunction

    // Offer one hit beat and hold it until the block takes it. Enter and
    // leave on a falling edge.
    task automatic send_hit(logic [4:0] ch, logic [15:0] en, bit last);
        int g;
        g = draw_gap(snd_calm);
        if (g > 0) begin
            s_tvalid = 1'b0;
            repeat (g) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {3'b000, en, ch};
        s_tlast  = last;
        do @(posedge aclk); while (!s_tready);
        sb.accept_hit(ch, en, last);
        @(negedge aclk);
    endtask

    // Let every expected result drain, allow the divider to settle, then
    // write adjacent_mode.
    task automatic set_mode(bit mode);
        s_tvalid = 1'b0;
        while (sb.pending_centroids.size() != 0)
            @(negedge aclk);
        repeat (DRAIN_WAIT) @(negedge aclk);
        cfg_we    = 1'b1;
        cfg_wdata = mode;
        @(negedge aclk);
        cfg_we    = 1'b0;
        sb.adjacent = mode;
    endtask

    function automatic logic [15:0] pick_energy();
        case ($urandom_range(0, 9))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'($urandom_range(1, 255));
            default: return 16'($urandom);
        endcase
    endfunction

    // One random event; returns the number of hits sent.
    task automatic random_event(bit mode, bit force_long, output int len);
        logic [4:0]  first;
        logic [4:0]  ch;
        logic [15:0] en;
        bit          dark;
        int          r;
        r = $urandom_range(0, 19);
        if (force_long || r == 0)
            len = $urandom_range(MAX_HITS + 1, MAX_HITS + 8);
        else if (r < 4)
            len = 1;
        else
            len = $urandom_range(2, 8);
        dark = ($urandom_range(0, 19) == 0);
        case ($urandom_range(0, 5))
            0:       first = 5'd0;
            1:       first = 5'd31;
            default: first = 5'($urandom);
        endcase
        for (int i = 0; i < len; i++) begin
            if (i == 0) begin
                ch = first;
            end else if (mode && $urandom_range(0, 9) < 7) begin
                case ($urandom_range(0, 2))
                    0:       ch = first + 5'd1;
                    1:       ch = first - 5'd1;
                    default: ch = first;
                endcase
            end else begin
                ch = 5'($urandom);
            end
            en = dark ? 16'h0000 : pick_energy();
            send_hit(ch, en, i == len - 1);
        end
    endtask

    task automatic random_phase(bit mode, int target, bit stall);
        int sent;
        int len;
        sent = 0;
        set_mode(mode);
        // request the long hold-off once the mode is set, so hits keep coming
        if (stall)
            hold_burst = 1'b1;
        // open each phase with an event that runs past the hit limit
        random_event(mode, 1'b1, len);
        sent += len;
        while (sent < target) begin
            random_event(mode, 1'b0, len);
            sent += len;
        end
    endtask

    // Result side: random hold-offs, one long stall on request, check each beat.
    initial begin
        int g;
        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            if (hold_burst) begin
                m_tready = 1'b0;
                repeat (STALL_LEN) @(negedge aclk);
                hold_burst = 1'b0;
                burst_done = 1'b1;
            end
            g = draw_gap(rcv_calm);
            if (g > 0) begin
                m_tready = 1'b0;
                repeat (g) @(negedge aclk);
            end
            m_tready = 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            sb.check_centroid(m_tdata, m_tuser);
            @(negedge aclk);
        end
    end

    initial begin
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        aresetn   = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tlast   = 1'b0;
        repeat (6) @(negedge aclk);
        aresetn = 1'b1;

        // Directed: all hits counted.
        set_mode(1'b0);
        send_hit(5'd31, 16'hFFFF, 1'b1);          // single hit, top channel
        send_hit(5'd0,  16'hFFFF, 1'b1);          // single hit, channel zero
        send_hit(5'd5,  16'h0000, 1'b0);          // zero energy sum
        send_hit(5'd9,  16'h0000, 1'b1);
        send_hit(5'd0,  16'hFFFF, 1'b0);          // both ends, full energy
        send_hit(5'd31, 16'hFFFF, 1'b1);

        // Directed: first hit and its neighbors only.
        set_mode(1'b1);
        send_hit(5'd0,  16'd100,  1'b0);          // first at zero: only 1 is next to it
        send_hit(5'd1,  16'd200,  1'b0);
        send_hit(5'd31, 16'd300,  1'b0);
        send_hit(5'd2,  16'd50,   1'b1);
        send_hit(5'd31, 16'hFFFF, 1'b0);          // first at top: 0 does not wrap
        send_hit(5'd30, 16'd10,   1'b0);
        send_hit(5'd0,  16'd5,    1'b1);
        send_hit(5'd10, 16'h0000, 1'b1);          // empty single hit
        send_hit(5'd15, 16'd1000, 1'b0);
        send_hit(5'd16, 16'd1000, 1'b0);
        send_hit(5'd14, 16'd1000, 1'b0);
        send_hit(5'd17, 16'd1,    1'b1);

        // Random phases; the first one runs against a long result stall.
        random_phase(1'b0, 130, 1'b1);
        random_phase(1'b1, 130, 1'b0);
        random_phase(1'b0, 130, 1'b0);
        random_phase(1'b1, 130, 1'b0);

        s_tvalid = 1'b0;
        while (sb.pending_centroids.size() != 0)
            @(negedge aclk);
        repeat (DRAIN_WAIT) @(negedge aclk);

        $display("run: %0d hits, %0d results (%0d empty), %0d hits past the limit",
                 sb.n_hits, sb.n_results, sb.n_empty, sb.n_dropped);
        $display("both adjacency modes, random idles, long result stall %0s",
                 burst_done ? "applied" : "missed");
        if (sb.errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

>>> wire_grid_energy_centroid.f
+incdir+rtl
rtl/wgec_pkg.sv
rtl/wgec_front.sv
rtl/wgec_queue.sv
rtl/wgec_back.sv
rtl/wire_grid_energy_centroid.sv
test/wire_grid_energy_centroid_tb.sv
